// File: design/twcc_pkg.sv
// Shared types and constants for the transport-wide feedback collector.
package twcc_pkg;

  localparam int unsigned Window    = 32;
  localparam int unsigned SlotW     = $clog2(Window);
  localparam int unsigned SpanW     = SlotW + 1;
  localparam int unsigned CfgIdxW   = 1;
  localparam int signed   WrapLimit = 32'sh0000FF00;

  localparam logic [CfgIdxW-1:0] CfgMaxPackets = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxDelta   = 1'b1;

  localparam logic [1:0] SymNone  = 2'd0;
  localparam logic [1:0] SymSmall = 2'd1;
  localparam logic [1:0] SymLarge = 2'd2;

  typedef struct packed {
    logic [31:0] stream_id;
    logic [15:0] sequence_req;
    logic [39:0] arrival_ms;
  } in_word_t;

  typedef struct packed {
    logic [31:0]        report_stream_id;
    logic [15:0]        entry_sequence;
    logic [1:0]         symbol;
    logic signed [15:0] receive_delta;
    logic [33:0]        reference_time;
    logic [7:0]         report_count;
    logic               last_of_report;
  } out_word_t;

  typedef enum logic [2:0] {
    StIdle,
    StClassify,
    StStore,
    StCheck,
    StRefRead,
    StWalk,
    StEmit
  } state_e;

endpackage

// File: design/twcc_feedback_collector_unit.sv
// Top level: packet store, classifier and sequential feedback report walker.
// Flow: a dropped packet passes through classify back to idle; a stored packet that
// causes no report passes through store and check; a report adds a reference read
// and, per entry, a slot read then an emit, plus any output stall.
// Throughput: one packet at a time; the report walk over the span (up to 32
// entries) through the single slot memory read port sets the rate.
// Reset clears control state, valid bits, counters and the config registers
// (max_packets 20, max_time_delta_ms 256); slot times are undefined until written.
module twcc_feedback_collector_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  twcc_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output twcc_pkg::out_word_t  out_word_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [twcc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  // slot memory
  logic [39:0] slot_mem [twcc_pkg::Window];
  logic [twcc_pkg::SlotW-1:0] rd_addr;
  logic [39:0] rd_data_q;
  logic        wr_en;

  twcc_pkg::state_e state_q, state_d;
  logic [twcc_pkg::Window-1:0] valid_q, valid_d;
  logic [15:0] oldest_q, oldest_d, newest_q, newest_d;
  logic [5:0]  count_q, count_d;
  logic [39:0] first_q, first_d, latest_q, latest_d;
  logic [7:0]  fbc_q, fbc_d;
  logic [5:0]  max_pkts_q;
  logic [15:0] max_delta_q;
  twcc_pkg::in_word_t pkt_q, pkt_d;
  logic        after_store_q, after_store_d;
  logic [twcc_pkg::SpanW-1:0] idx_q, idx_d;
  logic [twcc_pkg::SpanW:0]   span_q, span_d;
  logic [33:0] ref_q, ref_d;
  logic [39:0] last_q, last_d;
  twcc_pkg::out_word_t out_q, out_d;
  logic        out_v_q, out_v_d;

  logic [twcc_pkg::SlotW-1:0] pkt_slot;
  logic signed [17:0] dseq;
  logic [15:0] lo, hi, walk_seq;
  logic [16:0] width;
  logic [39:0] diff, spread;
  logic [15:0] d16;

  assign pkt_slot = pkt_q.sequence_req[twcc_pkg::SlotW-1:0];
  assign in_stall_o  = (state_q != twcc_pkg::StIdle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pkts_q  <= 6'd20;
      max_delta_q <= 16'd256;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        twcc_pkg::CfgMaxPackets: max_pkts_q  <= cfg_data_i[5:0];
        twcc_pkg::CfgMaxDelta:   max_delta_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // write and read the slot memory
  always_ff @(posedge clk_i) begin
    if (wr_en) slot_mem[pkt_slot] <= pkt_q.arrival_ms;
    rd_data_q <= slot_mem[rd_addr];
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= twcc_pkg::StIdle;
      valid_q <= '0;
      oldest_q <= '0;
      newest_q <= '0;
      count_q <= '0;
      first_q <= '0;
      latest_q <= '0;
      fbc_q <= '0;
      out_v_q <= 1'b0;
      after_store_q <= 1'b0;
      idx_q <= '0;
      span_q <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      oldest_q <= oldest_d;
      newest_q <= newest_d;
      count_q <= count_d;
      first_q <= first_d;
      latest_q <= latest_d;
      fbc_q <= fbc_d;
      out_v_q <= out_v_d;
      after_store_q <= after_store_d;
      idx_q <= idx_d;
      span_q <= span_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pkt_q  <= pkt_d;
    ref_q  <= ref_d;
    last_q <= last_d;
    out_q  <= out_d;
  end

  // classify, store, check and walk
  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    oldest_d = oldest_q;
    newest_d = newest_q;
    count_d = count_q;
    first_d = first_q;
    latest_d = latest_q;
    fbc_d = fbc_q;
    pkt_d = pkt_q;
    after_store_d = after_store_q;
    idx_d = idx_q;
    span_d = span_q;
    ref_d = ref_q;
    last_d = last_q;
    out_d = out_q;
    out_v_d = out_v_q && out_stall_i;
    wr_en = 1'b0;
    rd_addr = oldest_q[twcc_pkg::SlotW-1:0];
    dseq = $signed({2'b00, pkt_q.sequence_req}) - $signed({2'b00, newest_q});
    lo = (pkt_q.sequence_req < oldest_q) ? pkt_q.sequence_req : oldest_q;
    hi = (pkt_q.sequence_req > newest_q) ? pkt_q.sequence_req : newest_q;
    width = {1'b0, hi} - {1'b0, lo} + 17'd1;
    spread = latest_q - first_q;
    walk_seq = oldest_q + 16'(idx_q);
    diff = rd_data_q - last_q;
    d16 = {diff[13:0], 2'b00};

    case (state_q)
      twcc_pkg::StIdle: begin
        if (in_valid_i) begin
          pkt_d = in_word_i;
          state_d = twcc_pkg::StClassify;
        end
      end
      twcc_pkg::StClassify: begin
        if (count_q == '0) begin
          state_d = twcc_pkg::StStore;
        end else if (dseq < -18'sd65280) begin
          after_store_d = 1'b0;
          state_d = twcc_pkg::StRefRead;
        end else if (dseq > 18'sd65280) begin
          state_d = twcc_pkg::StIdle;
        end else if (width > 17'(twcc_pkg::Window) || valid_q[pkt_slot]) begin
          state_d = twcc_pkg::StIdle;
        end else begin
          state_d = twcc_pkg::StStore;
        end
      end
      twcc_pkg::StStore: begin
        wr_en = 1'b1;
        if (count_q == '0) begin
          oldest_d = pkt_q.sequence_req;
          newest_d = pkt_q.sequence_req;
          first_d = pkt_q.arrival_ms;
        end else begin
          if (pkt_q.sequence_req < oldest_q) oldest_d = pkt_q.sequence_req;
          if (pkt_q.sequence_req > newest_q) newest_d = pkt_q.sequence_req;
        end
        valid_d[pkt_slot] = 1'b1;
        count_d = count_q + 6'd1;
        latest_d = pkt_q.arrival_ms;
        state_d = twcc_pkg::StCheck;
      end
      twcc_pkg::StCheck: begin
        if (count_q >= max_pkts_q || spread >= {24'd0, max_delta_q}) begin
          after_store_d = 1'b1;
          state_d = twcc_pkg::StRefRead;
        end else begin
          state_d = twcc_pkg::StIdle;
        end
      end
      twcc_pkg::StRefRead: begin
        // rd_data_q now holds the oldest slot time
        ref_d = rd_data_q[39:6];
        last_d = {rd_data_q[39:6], 6'd0};
        span_d = (twcc_pkg::SpanW+1)'(newest_q - oldest_q + 16'd1);
        idx_d = '0;
        rd_addr = oldest_q[twcc_pkg::SlotW-1:0];
        state_d = twcc_pkg::StWalk;
      end
      twcc_pkg::StWalk: begin
        // fetch the slot for this entry
        rd_addr = walk_seq[twcc_pkg::SlotW-1:0];
        state_d = twcc_pkg::StEmit;
      end
      twcc_pkg::StEmit: begin
        rd_addr = walk_seq[twcc_pkg::SlotW-1:0];
        if (!(out_v_q && out_stall_i)) begin
          out_v_d = 1'b1;
          out_d.report_stream_id = pkt_q.stream_id;
          out_d.entry_sequence = walk_seq;
          out_d.reference_time = ref_q;
          out_d.report_count = fbc_q;
          out_d.last_of_report = ({1'b0, idx_q} + 1'b1 == span_q);
          if (valid_q[walk_seq[twcc_pkg::SlotW-1:0]]) begin
            out_d.receive_delta = d16;
            out_d.symbol = (d16[15] || d16 > 16'h00FF) ? twcc_pkg::SymLarge
                                                       : twcc_pkg::SymSmall;
            last_d = rd_data_q;
          end else begin
            out_d.receive_delta = '0;
            out_d.symbol = twcc_pkg::SymNone;
          end
          if (out_d.last_of_report || idx_q == twcc_pkg::SpanW'(twcc_pkg::Window - 1)) begin
            fbc_d = fbc_q + 8'd1;
            valid_d = '0;
            count_d = '0;
            first_d = '0;
            state_d = after_store_q ? twcc_pkg::StIdle : twcc_pkg::StStore;
          end else begin
            idx_d = idx_q + 1'b1;
            state_d = twcc_pkg::StWalk;
          end
        end
      end
      default: state_d = twcc_pkg::StIdle;
    endcase
  end

  // no word is taken while a packet is in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != twcc_pkg::StIdle) |-> in_stall_o)
    else $error("input taken while busy");
  // stored count matches the valid bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == twcc_pkg::StIdle) |-> ($countones(valid_q) == 32'(count_q)))
    else $error("stored count out of step with valid bits");
  // results only come out of the emit step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == twcc_pkg::StEmit))
    else $error("result outside report walk");

endmodule
